[rtl/slr_pkg.sv]
// Shared types and constants for the shaded line rasterizer.
`default_nettype none
package slr_pkg;

   localparam int COORD_W = 6;
   localparam int COLOR_W = 8;
   localparam int NUM_CH  = 3;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int DEC_W   = COORD_W + 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic ACTION_MOVE = 1'b0;
   localparam logic ACTION_DRAW = 1'b1;

   typedef enum logic [1:0] {
      OCT_STEEP_POS,
      OCT_SHALLOW_POS,
      OCT_SHALLOW_NEG,
      OCT_STEEP_NEG
   } octant_type;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic [COLOR_W-1:0] point_red;
      logic [COLOR_W-1:0] point_green;
      logic [COLOR_W-1:0] point_blue;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [COLOR_W-1:0] pixel_red;
      logic [COLOR_W-1:0] pixel_green;
      logic [COLOR_W-1:0] pixel_blue;
      logic               last_pixel;
   } rsp_type;

   typedef struct packed {
      octant_type                       octant;
      logic [COORD_W-1:0]               start_x;
      logic [COORD_W-1:0]               start_y;
      logic signed [DIFF_W-1:0]         delta_x;
      logic signed [DIFF_W-1:0]         delta_y;
      logic signed [DEC_W-1:0]          decision;
      logic [COORD_W-1:0]               span;
      logic [NUM_CH-1:0][COLOR_W-1:0]   start_color;
      logic [NUM_CH-1:0][COLOR_W-1:0]   end_color;
   } job_type;

endpackage
`default_nettype wire

[rtl/shaded_line_rasterizer.sv]
// Top level of the shaded line rasterizer.
//
//   channel   ports            payload    direction
//   request   req_valid/stall  req_type   in   (move or draw item)
//   response  rsp_valid/stall  rsp_type   out  (one pixel per transfer)
//
// A move only updates the current point in the front end. A draw is
// handled in the back end in steps: load the job, run the serial divider
// that sets the per-pixel color step, a fixup, then one pixel per cycle
// from the midpoint stepper while the response is not stalled. A two-entry
// job queue lets the front end take items while the back end draws.
// Reset (synchronous, active high) clears the current point and color to
// zero and empties the queue. Response stalls hold the output register and
// freeze the stepper; a full queue raises req_stall.
`default_nettype none
module shaded_line_rasterizer import slr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    push, full, not_empty, pop;
   job_type push_job, head_job;

   // classify draw items and track the current point
   slr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (full),
      .push_valid (push),
      .push_job   (push_job)
   );

   // hold pending line jobs
   slr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (full),
      .not_empty (not_empty),
      .pop       (pop),
      .head_job  (head_job)
   );

   // step each line and drive the response transfer
   slr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (not_empty),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[rtl/slr_front.sv]
// Front end: holds the current point, classifies draw items into line jobs.
`default_nettype none
module slr_front import slr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         push_valid,
   output job_type      push_job
);

   logic [COORD_W-1:0]             cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]             cur_y_ff, cur_y_in;
   logic [NUM_CH-1:0][COLOR_W-1:0] cur_c_ff, cur_c_in;
   logic                           accept;
   logic [NUM_CH-1:0][COLOR_W-1:0] new_c;
   logic signed [DIFF_W-1:0]       dx, dy, adx, sdy, ndx, ndy;
   logic signed [DEC_W-1:0]        ex, ey;
   logic                           swap;
   octant_type                     oct;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign new_c     = {req_data.point_blue, req_data.point_green, req_data.point_red};

   always_comb begin
      dx  = $signed({1'b0, req_data.point_x}) - $signed({1'b0, cur_x_ff});
      dy  = $signed({1'b0, req_data.point_y}) - $signed({1'b0, cur_y_ff});
      adx = dx[DIFF_W-1] ? -dx : dx;
      sdy = dx[DIFF_W-1] ? -dy : dy;
      if (dx == '0 || sdy > adx) begin
         oct  = OCT_STEEP_POS;
         swap = dy[DIFF_W-1];
      end else if (sdy >= 0) begin
         oct  = OCT_SHALLOW_POS;
         swap = dx[DIFF_W-1];
      end else if (sdy >= -adx) begin
         oct  = OCT_SHALLOW_NEG;
         swap = dx[DIFF_W-1];
      end else begin
         oct  = OCT_STEEP_NEG;
         swap = !dy[DIFF_W-1] && dy != '0;
      end
      ndx = swap ? -dx : dx;
      ndy = swap ? -dy : dy;
      ex  = DEC_W'(ndx);
      ey  = DEC_W'(ndy);
      push_job.octant      = oct;
      push_job.start_x     = swap ? req_data.point_x : cur_x_ff;
      push_job.start_y     = swap ? req_data.point_y : cur_y_ff;
      push_job.delta_x     = ndx;
      push_job.delta_y     = ndy;
      push_job.start_color = swap ? new_c : cur_c_ff;
      push_job.end_color   = swap ? cur_c_ff : new_c;
      unique case (oct)
         OCT_STEEP_POS: begin
            push_job.decision = DEC_W'(2 * ex - ey);
            push_job.span     = ndy[COORD_W-1:0];
         end
         OCT_SHALLOW_POS: begin
            push_job.decision = DEC_W'(ex - 2 * ey);
            push_job.span     = ndx[COORD_W-1:0];
         end
         OCT_SHALLOW_NEG: begin
            push_job.decision = DEC_W'(-ex - 2 * ey);
            push_job.span     = ndx[COORD_W-1:0];
         end
         default: begin
            push_job.decision = DEC_W'(-2 * ex - ey);
            push_job.span     = COORD_W'(-ndy);
         end
      endcase
      // drop zero-length lines and moves
      push_valid = accept && req_data.action == ACTION_DRAW && push_job.span != '0;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_c_in = cur_c_ff;
      if (accept) begin
         cur_x_in = req_data.point_x;
         cur_y_in = req_data.point_y;
         cur_c_in = new_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         cur_c_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         cur_c_ff <= cur_c_in;
      end
   end

endmodule
`default_nettype wire

[rtl/slr_queue.sv]
// Short job queue between the front and back ends.
`default_nettype none
module slr_queue import slr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   output logic         not_empty,
   input  wire logic    pop,
   output job_type      head_job
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;

   assign full      = cnt_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head_job  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[rtl/slr_back.sv]
// Back end: color step setup by serial division, then midpoint stepping.
`default_nettype none
module slr_back import slr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_ready,
   input  wire job_type head_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {IDLE, DIVIDE, FIXUP, RUN} state_type;

   localparam int DIV_CNT_W = $clog2(COLOR_W);

   state_type                       state_ff;
   job_type                         job_ff;
   logic [COORD_W-1:0]              x_ff, y_ff, cnt_ff;
   logic signed [DEC_W-1:0]         d_ff;
   logic [NUM_CH-1:0][COLOR_W-1:0]  col_ff, qd_ff, mag_ff, dq_ff;
   logic [NUM_CH-1:0][COORD_W:0]    dr_ff, rem_ff;
   logic [NUM_CH-1:0][COORD_W-1:0]  rd_ff;
   logic [NUM_CH-1:0]               neg_ff;
   logic [DIV_CNT_W-1:0]            div_ff;
   logic                            rsp_valid_ff;
   rsp_type                         rsp_ff;

   logic                            out_free;
   logic signed [DEC_W-1:0]         ex, ey;
   logic [NUM_CH-1:0][COORD_W:0]    shifted, rsum;
   logic [NUM_CH-1:0][COLOR_W:0]    diff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = state_ff == IDLE && job_ready;
   assign ex        = DEC_W'(job_ff.delta_x);
   assign ey        = DEC_W'(job_ff.delta_y);

   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         diff[i]    = {1'b0, head_job.end_color[i]} - {1'b0, head_job.start_color[i]};
         shifted[i] = {dr_ff[i][COORD_W-1:0], mag_ff[i][COLOR_W-1]};
         rsum[i]    = rem_ff[i] + {1'b0, rd_ff[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // outside the run the output register only empties
         if (rsp_valid_ff && !rsp_stall && state_ff != RUN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (job_ready) begin
                  job_ff <= head_job;
                  x_ff   <= head_job.start_x;
                  y_ff   <= head_job.start_y;
                  d_ff   <= head_job.decision;
                  cnt_ff <= head_job.span;
                  div_ff <= '0;
                  for (int i = 0; i < NUM_CH; i++) begin
                     neg_ff[i] <= diff[i][COLOR_W];
                     mag_ff[i] <= diff[i][COLOR_W] ? COLOR_W'(-diff[i])
                                                   : diff[i][COLOR_W-1:0];
                     col_ff[i] <= head_job.start_color[i];
                     rem_ff[i] <= '0;
                     dr_ff[i]  <= '0;
                     dq_ff[i]  <= '0;
                  end
                  state_ff <= DIVIDE;
               end
            end
            DIVIDE: begin
               // restoring divide, one quotient bit per cycle
               for (int i = 0; i < NUM_CH; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
                  if (shifted[i] >= {1'b0, job_ff.span}) begin
                     dr_ff[i] <= shifted[i] - {1'b0, job_ff.span};
                     dq_ff[i] <= {dq_ff[i][COLOR_W-2:0], 1'b1};
                  end else begin
                     dr_ff[i] <= shifted[i];
                     dq_ff[i] <= {dq_ff[i][COLOR_W-2:0], 1'b0};
                  end
               end
               div_ff <= div_ff + 1'b1;
               if (div_ff == DIV_CNT_W'(COLOR_W - 1)) begin
                  state_ff <= FIXUP;
               end
            end
            FIXUP: begin
               // floor the step for a falling channel
               for (int i = 0; i < NUM_CH; i++) begin
                  if (!neg_ff[i]) begin
                     qd_ff[i] <= dq_ff[i];
                     rd_ff[i] <= dr_ff[i][COORD_W-1:0];
                  end else if (dr_ff[i] == '0) begin
                     qd_ff[i] <= -dq_ff[i];
                     rd_ff[i] <= '0;
                  end else begin
                     qd_ff[i] <= -dq_ff[i] - 1'b1;
                     rd_ff[i] <= job_ff.span - dr_ff[i][COORD_W-1:0];
                  end
               end
               state_ff <= RUN;
            end
            RUN: begin
               if (out_free) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.pixel_x      <= x_ff;
                  rsp_ff.pixel_y      <= y_ff;
                  rsp_ff.pixel_red    <= col_ff[0];
                  rsp_ff.pixel_green  <= col_ff[1];
                  rsp_ff.pixel_blue   <= col_ff[2];
                  rsp_ff.last_pixel   <= cnt_ff == COORD_W'(1);
                  for (int i = 0; i < NUM_CH; i++) begin
                     if (rsum[i] >= {1'b0, job_ff.span}) begin
                        rem_ff[i] <= rsum[i] - {1'b0, job_ff.span};
                        col_ff[i] <= col_ff[i] + qd_ff[i] + 1'b1;
                     end else begin
                        rem_ff[i] <= rsum[i];
                        col_ff[i] <= col_ff[i] + qd_ff[i];
                     end
                  end
                  unique case (job_ff.octant)
                     OCT_STEEP_POS: begin
                        y_ff <= y_ff + 1'b1;
                        if (d_ff >= 0) begin
                           x_ff <= x_ff + 1'b1;
                           d_ff <= DEC_W'(d_ff + 2 * ex - 2 * ey);
                        end else begin
                           d_ff <= DEC_W'(d_ff + 2 * ex);
                        end
                     end
                     OCT_SHALLOW_POS: begin
                        x_ff <= x_ff + 1'b1;
                        if (d_ff < 0) begin
                           y_ff <= y_ff + 1'b1;
                           d_ff <= DEC_W'(d_ff + 2 * ex - 2 * ey);
                        end else begin
                           d_ff <= DEC_W'(d_ff - 2 * ey);
                        end
                     end
                     OCT_SHALLOW_NEG: begin
                        x_ff <= x_ff + 1'b1;
                        if (d_ff > 0) begin
                           y_ff <= y_ff - 1'b1;
                           d_ff <= DEC_W'(d_ff - 2 * ex - 2 * ey);
                        end else begin
                           d_ff <= DEC_W'(d_ff - 2 * ey);
                        end
                     end
                     default: begin
                        y_ff <= y_ff - 1'b1;
                        if (d_ff < 0) begin
                           x_ff <= x_ff + 1'b1;
                           d_ff <= DEC_W'(d_ff - 2 * ex - 2 * ey);
                        end else begin
                           d_ff <= DEC_W'(d_ff - 2 * ex);
                        end
                     end
                  endcase
                  cnt_ff <= cnt_ff - 1'b1;
                  if (cnt_ff == COORD_W'(1)) begin
                     state_ff <= IDLE;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

[bench/tb.sv]
// Testbench for the shaded line rasterizer: directed and random moves and draws.
`default_nettype none
module tb;
   import slr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   shaded_line_rasterizer DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: the current point and its color.
   int      pen_x, pen_y;
   int      pen_col [3];
   rsp_type pixel_queue [$];
   int      error_count = 0;
   int      idle_cycles = 0;
   bit      stall_enable = 1'b1;

   localparam int WATCHDOG_LIMIT = 20000;

   // Build one expected pixel with floored linear color interpolation.
   function automatic rsp_type make_pixel(int x, int y, int sc[3], int ec[3],
                                          int pos, int from, int to, bit last);
      rsp_type r;
      int span, w0, w1;
      int v [3];
      span = (to > from) ? to - from : from - to;
      w0 = (to > pos) ? to - pos : pos - to;
      w1 = (pos > from) ? pos - from : from - pos;
      for (int i = 0; i < 3; i++)
         v[i] = (span != 0) ? (sc[i] * w0 + ec[i] * w1) / span : 0;
      r.pixel_x = x[5:0];
      r.pixel_y = y[5:0];
      r.pixel_red = v[0][7:0];
      r.pixel_green = v[1][7:0];
      r.pixel_blue = v[2][7:0];
      r.last_pixel = last;
      return r;
   endfunction

   // Rasterize one item into pixel_queue and advance the current point.
   task automatic predict_pixels(req_type it);
      int px, py, qx, qy, tx, ty, dx, dy, adx, sdy, d, x, y;
      int pc [3];
      int qc [3];
      int tc [3];
      px = pen_x; py = pen_y; pc = pen_col;
      qx = it.point_x; qy = it.point_y;
      qc[0] = it.point_red; qc[1] = it.point_green; qc[2] = it.point_blue;
      if (it.action == ACTION_DRAW) begin
         dx = qx - px;
         dy = qy - py;
         adx = (dx < 0) ? -dx : dx;
         sdy = (dx < 0) ? -dy : dy;
         // Each case swaps endpoints into its stepping direction.
         if (dx == 0) begin
            if (py > qy) begin
               tx = px; ty = py; tc = pc; px = qx; py = qy; pc = qc;
               qx = tx; qy = ty; qc = tc;
            end
            for (y = py; y < qy; y++)
               pixel_queue.push_back(make_pixel(px, y, pc, qc, y, py, qy, y == qy - 1));
         end else if (sdy > adx) begin
            if (py > qy) begin
               tx = px; ty = py; tc = pc; px = qx; py = qy; pc = qc;
               qx = tx; qy = ty; qc = tc;
            end
            dx = qx - px; dy = qy - py; d = 2 * dx - dy; x = px;
            for (y = py; y < qy; y++) begin
               pixel_queue.push_back(make_pixel(x, y, pc, qc, y, py, qy, y == qy - 1));
               if (d >= 0) begin x++; d += 2 * dx - 2 * dy; end
               else d += 2 * dx;
            end
         end else if (sdy >= 0) begin
            if (px > qx) begin
               tx = px; ty = py; tc = pc; px = qx; py = qy; pc = qc;
               qx = tx; qy = ty; qc = tc;
            end
            dx = qx - px; dy = qy - py; d = dx - 2 * dy; y = py;
            for (x = px; x < qx; x++) begin
               pixel_queue.push_back(make_pixel(x, y, pc, qc, x, px, qx, x == qx - 1));
               if (d < 0) begin y++; d += 2 * dx - 2 * dy; end
               else d -= 2 * dy;
            end
         end else if (sdy >= -adx) begin
            if (px > qx) begin
               tx = px; ty = py; tc = pc; px = qx; py = qy; pc = qc;
               qx = tx; qy = ty; qc = tc;
            end
            dx = qx - px; dy = qy - py; d = -dx - 2 * dy; y = py;
            for (x = px; x < qx; x++) begin
               pixel_queue.push_back(make_pixel(x, y, pc, qc, x, px, qx, x == qx - 1));
               if (d > 0) begin y--; d -= 2 * dx + 2 * dy; end
               else d -= 2 * dy;
            end
         end else begin
            if (py < qy) begin
               tx = px; ty = py; tc = pc; px = qx; py = qy; pc = qc;
               qx = tx; qy = ty; qc = tc;
            end
            dx = qx - px; dy = qy - py; d = -2 * dx - dy; x = px;
            for (y = py; y > qy; y--) begin
               pixel_queue.push_back(make_pixel(x, y, pc, qc, y, py, qy, y == qy + 1));
               if (d < 0) begin x++; d -= 2 * dx + 2 * dy; end
               else d -= 2 * dx;
            end
         end
      end
      // The target point becomes current, swaps notwithstanding.
      pen_x = it.point_x;
      pen_y = it.point_y;
      pen_col[0] = it.point_red;
      pen_col[1] = it.point_green;
      pen_col[2] = it.point_blue;
   endtask

   // Mostly short gaps, a few long ones.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Send one item: hold valid and the payload until the transfer happens.
   // Valid stays high into a back-to-back item; drop it only for a gap.
   task automatic send_item(logic act, int x, int y, int r, int g, int b);
      req_type it;
      int gap;
      it.action = act;
      it.point_x = x[5:0];
      it.point_y = y[5:0];
      it.point_red = r[7:0];
      it.point_green = g[7:0];
      it.point_blue = b[7:0];
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixels(it);
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(logic act);
      send_item(act, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // Drop valid, then wait until every expected pixel has been transferred.
   task automatic drain_pixels();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
   endtask

   // Zero-length line, every slope case, edges of the tile and color extremes.
   task automatic test_directed();
      send_item(ACTION_DRAW, 0, 0, 255, 0, 255);      // zero length from reset
      send_item(ACTION_DRAW, 0, 63, 0, 255, 0);       // vertical, full height
      send_item(ACTION_DRAW, 0, 0, 255, 255, 255);    // vertical, upward swap
      send_item(ACTION_DRAW, 63, 0, 0, 0, 0);         // horizontal, full width
      send_item(ACTION_DRAW, 0, 63, 255, 128, 1);     // shallow negative at -1
      send_item(ACTION_MOVE, 10, 10, 200, 100, 50);
      send_item(ACTION_DRAW, 20, 40, 0, 255, 7);      // steep positive
      send_item(ACTION_DRAW, 10, 10, 3, 4, 5);        // steep positive, swapped
      send_item(ACTION_DRAW, 50, 20, 255, 0, 0);      // shallow positive
      send_item(ACTION_DRAW, 10, 30, 9, 9, 9);        // shallow negative
      send_item(ACTION_DRAW, 20, 0, 0, 0, 255);       // steep negative
      send_item(ACTION_DRAW, 10, 20, 77, 88, 99);     // steep negative, swapped
      send_item(ACTION_DRAW, 20, 30, 1, 2, 3);        // diagonal slope one
      send_item(ACTION_DRAW, 63, 63, 255, 255, 255);
      send_item(ACTION_DRAW, 0, 0, 0, 0, 0);          // main diagonal
      send_item(ACTION_MOVE, 63, 0, 170, 85, 170);
      send_item(ACTION_DRAW, 0, 63, 85, 170, 85);     // anti-diagonal
      send_item(ACTION_DRAW, 0, 63, 1, 1, 1);         // zero length
   endtask

   // Pause the sender until all pixels are out, then resume.
   task automatic test_drain_pause();
      send_random(ACTION_DRAW);
      send_random(ACTION_DRAW);
      drain_pixels();
      send_random(ACTION_DRAW);
   endtask

   // Random traffic: mostly draws, short lines weighted in, some moves.
   task automatic test_random(int count);
      int r, x0, y0;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (n == count / 2) stall_enable = 1'b0;       // stretch with no stalls
         if (n == count / 2 + 30) stall_enable = 1'b1;
         if (r < 20) send_random(ACTION_MOVE);
         else if (r < 50) begin
            x0 = pen_x + $urandom_range(0, 8) - 4;
            y0 = pen_y + $urandom_range(0, 8) - 4;
            if (x0 < 0) x0 = 0;
            if (x0 > 63) x0 = 63;
            if (y0 < 0) y0 = 0;
            if (y0 > 63) y0 = 63;
            send_item(ACTION_DRAW, x0, y0, $urandom_range(0, 255),
                      $urandom_range(0, 255), $urandom_range(0, 255));
         end else send_random(ACTION_DRAW);
      end
   endtask

   // Response stall: random gaps, disabled on request.
   initial begin
      int hold;
      forever begin
         hold = stall_enable ? gap_length() : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Check each transferred pixel against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_queue.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d", rsp_data.pixel_x, rsp_data.pixel_y);
            error_count++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $error("pixel_x expected %0d actual %0d", want.pixel_x, rsp_data.pixel_x);
               error_count++;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $error("pixel_y expected %0d actual %0d", want.pixel_y, rsp_data.pixel_y);
               error_count++;
            end
            if (rsp_data.pixel_red !== want.pixel_red) begin
               $error("pixel_red expected %0d actual %0d", want.pixel_red,
                      rsp_data.pixel_red);
               error_count++;
            end
            if (rsp_data.pixel_green !== want.pixel_green) begin
               $error("pixel_green expected %0d actual %0d", want.pixel_green,
                      rsp_data.pixel_green);
               error_count++;
            end
            if (rsp_data.pixel_blue !== want.pixel_blue) begin
               $error("pixel_blue expected %0d actual %0d", want.pixel_blue,
                      rsp_data.pixel_blue);
               error_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel expected %0d actual %0d", want.last_pixel,
                      rsp_data.last_pixel);
               error_count++;
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("shaded_line_rasterizer verification failed");
         $finish;
      end
   end

   initial begin
      pen_x = 0;
      pen_y = 0;
      pen_col = '{0, 0, 0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_drain_pause();
      test_random(260);
      drain_pixels();
      repeat (40) @(posedge clock);
      if (error_count == 0 && pixel_queue.size() == 0)
         $display("shaded_line_rasterizer verification clean");
      else
         $display("shaded_line_rasterizer verification failed");
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
rtl/slr_pkg.sv
rtl/slr_front.sv
rtl/slr_queue.sv
rtl/slr_back.sv
rtl/shaded_line_rasterizer.sv
bench/tb.sv
